// ===== src/aed_pkg.sv =====
// shared constants, types and codes of the adc event word decoder
package aed_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int STAMP_WIDTH   = 48;
  localparam int MAX_RESULTS   = 32;
  localparam int STORE_CAP     = (PENDING_DEPTH < MAX_RESULTS) ? PENDING_DEPTH : MAX_RESULTS;
  localparam int IDX_W         = (STORE_CAP > 1) ? $clog2(STORE_CAP) : 1;
  localparam int CNT_W         = $clog2(STORE_CAP + 1);
  localparam int ADDR_W        = IDX_W + 1;
  localparam int MEM_DEPTH     = 2 ** ADDR_W;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULE_ID      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_MODE = 4'd1;

  localparam logic [9:0]  HIT_TAG       = 10'd16;
  localparam logic [15:0] LOW_STAMP_TAG = 16'd1152;
  localparam logic [1:0]  TOP_HEADER    = 2'b01;
  localparam logic [1:0]  TOP_EOE       = 2'b11;
  localparam logic [15:0] OVF_CHARGE    = 16'hFFFF;

  typedef logic [STAMP_WIDTH-1:0] stamp_t;

  typedef enum logic {
    CMD_SINGLE,
    CMD_DRAIN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             bank;
    logic [CNT_W-1:0] cnt;
    logic [4:0]       channel;
    logic [15:0]      charge;
    stamp_t           timestamp;
    logic             stamp_ok;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  channel;
    logic [15:0] charge;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } store_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } drain_done_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } back_state_e;

endpackage

// ===== src/aed_if.sv =====
// stream interfaces for readout words in and decoded hits out
interface aed_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        end_of_transfer;

  modport source(output valid, data_word, end_of_transfer, input ready);
  modport sink(input valid, data_word, end_of_transfer, output ready);
endinterface

interface aed_hit_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      module_number;
  logic [4:0]                      channel;
  logic [aed_pkg::STAMP_WIDTH-1:0] timestamp;
  logic                            timestamp_valid;
  logic [15:0]                     charge;
  logic                            last;

  modport source(output valid, module_number, channel, timestamp, timestamp_valid, charge,
                 last, input ready);
  modport sink(input valid, module_number, channel, timestamp, timestamp_valid, charge,
               last, output ready);
endinterface

// ===== src/aed_front.sv =====
// front end: accepts and classifies words, keeps stamp state, fills the pending store
module aed_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  aed_word_if.sink             word_i,
  input  logic                 mode_i,
  input  logic                 cfg_clear_i,
  input  logic                 queue_full_i,
  input  aed_pkg::drain_done_t done_i,
  output logic                 push_o,
  output aed_pkg::cmd_t        cmd_o,
  output aed_pkg::store_wr_t   wr_o
);
  import aed_pkg::*;

  stamp_t           ctr_q, ctr_d;
  logic [15:0]      low_q, low_d;
  logic             seen_q, seen_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_st, drain_cnt;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic        accept;
  logic [31:0] w;
  logic        eot;
  logic [1:0]  top;
  logic        is_hit, is_low;
  logic [4:0]  ch;
  logic [15:0] q;
  logic        drain_go, drain_any, drain_valid, clr_stamp;
  stamp_t      drain_ts;

  assign word_i.ready = !queue_full_i && !busy_q[bank_q];
  assign accept       = word_i.valid && word_i.ready;
  assign w            = word_i.data_word;
  assign eot          = word_i.end_of_transfer;
  assign top          = w[31:30];
  assign is_hit       = (w[31:22] == HIT_TAG);
  assign is_low       = (w[31:16] == LOW_STAMP_TAG);
  assign ch           = w[20:16];
  assign q            = w[14] ? OVF_CHARGE : {2'b00, w[13:0]};

  always_comb begin
    ctr_d       = ctr_q;
    low_d       = low_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    cnt_st      = cnt_q;
    bank_d      = bank_q;
    busy_d      = busy_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    wr_o        = '0;
    drain_go    = 1'b0;
    drain_any   = 1'b0;
    drain_valid = 1'b0;
    drain_ts    = '0;
    drain_cnt   = '0;
    clr_stamp   = 1'b0;
    if (done_i.en) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (accept) begin
      if (!mode_i) begin
        if (is_hit) begin
          push_o             = 1'b1;
          cmd_o.kind         = CMD_SINGLE;
          cmd_o.channel      = ch;
          cmd_o.charge       = q;
          cmd_o.timestamp    = ctr_q;
          cmd_o.stamp_ok     = 1'b1;
        end else if (top == TOP_EOE) begin
          ctr_d = ctr_q + STAMP_WIDTH'(1);
        end
      end else begin
        priority if (top == TOP_HEADER) begin
          drain_go  = 1'b1;
          clr_stamp = 1'b1;
        end else if (is_hit) begin
          if (cnt_q < CNT_W'(STORE_CAP)) begin
            wr_o.en           = 1'b1;
            wr_o.addr         = {bank_q, cnt_q[IDX_W-1:0]};
            wr_o.data.channel = ch;
            wr_o.data.charge  = q;
            cnt_st            = cnt_q + CNT_W'(1);
          end else if (!eot) begin
            push_o        = 1'b1;
            cmd_o.kind    = CMD_SINGLE;
            cmd_o.channel = ch;
            cmd_o.charge  = q;
          end
        end else if (is_low) begin
          low_d  = w[15:0];
          seen_d = 1'b1;
        end else if (top == TOP_EOE) begin
          drain_go    = 1'b1;
          drain_valid = seen_q;
          drain_ts    = seen_q ? STAMP_WIDTH'({w[29:0], low_q}) : '0;
        end else begin
        end
      end
      if (drain_go) begin
        drain_any = 1'b1;
        drain_cnt = cnt_q;
      end else if (eot) begin
        drain_any = 1'b1;
        drain_cnt = cnt_st;
      end
      cnt_d = drain_any ? '0 : cnt_st;
      if (eot) begin
        clr_stamp = 1'b1;
      end
      if (clr_stamp) begin
        low_d  = '0;
        seen_d = 1'b0;
      end
      if (drain_any && (drain_cnt != '0)) begin
        push_o          = 1'b1;
        cmd_o.kind      = CMD_DRAIN;
        cmd_o.bank      = bank_q;
        cmd_o.cnt       = drain_cnt;
        cmd_o.timestamp = drain_ts;
        cmd_o.stamp_ok  = drain_valid;
        busy_d[bank_q]  = 1'b1;
        bank_d          = ~bank_q;
      end
    end
    if (cfg_clear_i) begin
      cnt_d  = '0;
      low_d  = '0;
      seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= '0;
      low_q  <= '0;
      seen_q <= 1'b0;
      cnt_q  <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      ctr_q  <= ctr_d;
      low_q  <= low_d;
      seen_q <= seen_d;
      cnt_q  <= cnt_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ===== src/aed_cmd_queue.sv =====
// short command queue between front and back end
module aed_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  aed_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output aed_pkg::cmd_t head_o
);
  import aed_pkg::*;

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/aed_back.sv =====
// back end: pending store memory, drain sequencer and output register
module aed_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           module_id_i,
  input  aed_pkg::store_wr_t   wr_i,
  input  logic                 head_valid_i,
  input  aed_pkg::cmd_t        head_i,
  output logic                 pop_o,
  output aed_pkg::drain_done_t done_o,
  aed_hit_if.source            hit_o
);
  import aed_pkg::*;

  entry_t           mem [MEM_DEPTH];
  entry_t           rdata_q;
  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             out_free, is_last, load, sel_mem, load_last;

  logic        out_valid_q;
  logic [4:0]  out_ch_q;
  logic [15:0] out_q_q;
  stamp_t      out_ts_q;
  logic        out_tsv_q;
  logic        out_last_q;

  assign out_free = !out_valid_q || hit_o.ready;
  assign is_last  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == head_i.cnt);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[{head_i.bank, rd_idx_q}];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i && (head_i.kind == CMD_DRAIN)) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: state_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          state_d = is_last ? BK_IDLE : BK_FETCH;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    done_o    = '0;
    load      = 1'b0;
    sel_mem   = 1'b0;
    load_last = 1'b0;
    rd_idx_d  = rd_idx_q;
    unique case (state_q)
      BK_IDLE: begin
        rd_idx_d = '0;
        if (head_valid_i && (head_i.kind == CMD_SINGLE) && out_free) begin
          load      = 1'b1;
          load_last = 1'b1;
          pop_o     = 1'b1;
        end
      end
      BK_FETCH: begin
      end
      BK_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          sel_mem = 1'b1;
          if (is_last) begin
            load_last   = 1'b1;
            pop_o       = 1'b1;
            done_o.en   = 1'b1;
            done_o.bank = head_i.bank;
            rd_idx_d    = '0;
          end else begin
            rd_idx_d = IDX_W'(rd_idx_q + 1'b1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (hit_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ch_q   <= sel_mem ? rdata_q.channel : head_i.channel;
      out_q_q    <= sel_mem ? rdata_q.charge : head_i.charge;
      out_ts_q   <= head_i.stamp_ok ? head_i.timestamp : '0;
      out_tsv_q  <= head_i.stamp_ok;
      out_last_q <= load_last;
    end
  end

  assign hit_o.valid           = out_valid_q;
  assign hit_o.module_number   = module_id_i;
  assign hit_o.channel         = out_ch_q;
  assign hit_o.timestamp       = out_ts_q;
  assign hit_o.timestamp_valid = out_tsv_q;
  assign hit_o.charge          = out_q_q;
  assign hit_o.last            = out_last_q;

endmodule

// ===== src/adc_event_word_decoder.sv =====
// top level of the adc event word decoder: config registers, front, queue and back end
//
// word_i carries 32-bit readout words with an end_of_transfer flag; hit_o carries decoded
// hits (module number, channel, 48-bit stamp with valid flag, charge, last of run).
// Both are valid/ready channels; a transfer happens on a clock edge with both high.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) go in while the block is idle:
// index 0 module id, index 1 stamping mode (0 event counter, 1 extended stamp).
// Writing the mode empties the pending store and the low stamp.
// A counter-mode hit passes through the command queue and the output register to hit_o.
// A drain of pending hits (end of event, header, end of transfer) is read out of a two-bank
// store memory one hit at a time, each in a fetch and an emit state for the registered read port.
// Words are taken one per cycle while the two-entry command queue has room and the
// store bank being filled is not still being drained.
// hit_o is a registered output: a stalled receiver holds the hit, the back end waits,
// and the front keeps taking words until the queue fills.
// Reset clears all control state, the event counter, the low stamp and the config
// registers; the store memory needs no clearing.
module adc_event_word_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aed_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [aed_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  aed_word_if.sink                        word_i,
  aed_hit_if.source                       hit_o
);
  import aed_pkg::*;

  logic [7:0]  module_id_q;
  logic        mode_q;
  logic        cfg_clear;
  logic        push, pop, full, head_valid;
  cmd_t        cmd, head;
  store_wr_t   wr;
  drain_done_t done;

  assign cfg_clear = cfg_we_i && (cfg_idx_i == CFG_TIMESTAMP_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_id_q <= '0;
      mode_q      <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODULE_ID) begin
        module_id_q <= cfg_data_i[7:0];
      end
      if (cfg_idx_i == CFG_TIMESTAMP_MODE) begin
        mode_q <= cfg_data_i[0];
      end
    end
  end

  aed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word_i),
    .mode_i       (mode_q),
    .cfg_clear_i  (cfg_clear),
    .queue_full_i (full),
    .done_i       (done),
    .push_o       (push),
    .cmd_o        (cmd),
    .wr_o         (wr)
  );

  aed_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  aed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .module_id_i  (module_id_q),
    .wr_i         (wr),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .done_o       (done),
    .hit_o        (hit_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("command pushed into full queue");

  a_no_write_to_draining_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && head_valid && (head.kind == CMD_DRAIN)) |-> (wr.addr[ADDR_W-1] != head.bank))
    else $error("store write into bank under drain");

  a_done_pops_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.en |-> (pop && head_valid && (head.kind == CMD_DRAIN)))
    else $error("drain finished without its command at the head");

endmodule

// ===== bench/tb_adc_event_word_decoder.sv =====
// testbench of the adc event word decoder: directed and random word streams checked hit by hit
`timescale 1ns / 100ps

module tb_adc_event_word_decoder;
  import aed_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int IDLE_PCT      = 20;
  localparam logic [1:0] TOP_PLAIN   = 2'b00;
  localparam logic [1:0] TOP_IGNORED = 2'b10;

  typedef struct packed {
    logic [7:0]  module_number;
    logic [4:0]  channel;
    stamp_t      timestamp;
    logic        timestamp_valid;
    logic [15:0] charge;
    logic        last;
  } hit_rec_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  aed_word_if word_if();
  aed_hit_if  hit_if();

  adc_event_word_decoder dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .word_i    (word_if),
    .hit_o     (hit_if)
  );

  logic [7:0]  cfg_module   = '0;
  logic        cfg_ext_mode = 1'b0;
  stamp_t      event_count  = '0;
  logic [15:0] low_stamp    = '0;
  logic        low_seen     = 1'b0;
  logic [4:0]  pend_chan   [STORE_CAP];
  logic [15:0] pend_charge [STORE_CAP];
  int          pend_cnt     = 0;

  hit_rec_t    expected_hits[$];
  hit_rec_t    run_hits[$];
  hit_rec_t    want_hit;
  int          errors        = 0;
  int unsigned cycle_count   = 0;
  logic        no_idle       = 1'b0;
  int          words_counted = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d hits outstanding", $time, expected_hits.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) hit_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

  // hit prediction
  function automatic void clear_stamp();
    low_stamp = '0;
    low_seen  = 1'b0;
  endfunction

  function automatic void add_hit(logic [4:0] ch, stamp_t ts, logic ok, logic [15:0] q);
    hit_rec_t h;
    h.module_number   = cfg_module;
    h.channel         = ch;
    h.timestamp       = ok ? ts : '0;
    h.timestamp_valid = ok;
    h.charge          = q;
    h.last            = 1'b0;
    run_hits.push_back(h);
  endfunction

  function automatic void flush_pending(stamp_t ts, logic ok);
    for (int i = 0; i < pend_cnt && run_hits.size() < MAX_RESULTS; i++) begin
      add_hit(pend_chan[i], ts, ok, pend_charge[i]);
    end
    pend_cnt = 0;
  endfunction

  function automatic void decode_word(logic [31:0] w, logic eot);
    logic        is_hit;
    logic [4:0]  ch;
    logic [15:0] q;
    hit_rec_t    h;
    is_hit = (w[31:22] == HIT_TAG);
    ch     = w[20:16];
    q      = w[14] ? OVF_CHARGE : {2'b00, w[13:0]};
    run_hits.delete();
    if (!cfg_ext_mode) begin
      if (is_hit) add_hit(ch, event_count, 1'b1, q);
      else if (w[31:30] == TOP_EOE) event_count = event_count + 1'b1;
    end else if (w[31:30] == TOP_HEADER) begin
      flush_pending('0, 1'b0);
      clear_stamp();
    end else if (is_hit) begin
      if (pend_cnt < STORE_CAP) begin
        pend_chan[pend_cnt]   = ch;
        pend_charge[pend_cnt] = q;
        pend_cnt++;
      end else if (!eot) begin
        add_hit(ch, '0, 1'b0, q);
      end
    end else if (w[31:16] == LOW_STAMP_TAG) begin
      low_stamp = w[15:0];
      low_seen  = 1'b1;
    end else if (w[31:30] == TOP_EOE) begin
      if (low_seen) flush_pending(stamp_t'({w[29:0], low_stamp}), 1'b1);
      else flush_pending('0, 1'b0);
    end
    if (eot) begin
      flush_pending('0, 1'b0);
      clear_stamp();
    end
    if (run_hits.size() > 0) begin
      h = run_hits.pop_back();
      h.last = 1'b1;
      run_hits.push_back(h);
    end
    foreach (run_hits[i]) expected_hits.push_back(run_hits[i]);
  endfunction

  // hit checking
  function automatic void check_field(string label, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && hit_if.valid && hit_if.ready) begin
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t unexpected hit: expected none actual channel %0h charge %0h",
                 $time, hit_if.channel, hit_if.charge);
      end else begin
        want_hit = expected_hits.pop_front();
        check_field("module_number", want_hit.module_number, hit_if.module_number);
        check_field("channel", want_hit.channel, hit_if.channel);
        check_field("timestamp", want_hit.timestamp, hit_if.timestamp);
        check_field("timestamp_valid", want_hit.timestamp_valid, hit_if.timestamp_valid);
        check_field("charge", want_hit.charge, hit_if.charge);
        check_field("last", want_hit.last, hit_if.last);
      end
    end
  end

  // word builders
  function automatic logic [31:0] hit_word(logic [4:0] ch, logic ovf, logic [13:0] q);
    return {HIT_TAG, 1'($urandom_range(0, 1)), ch, 1'($urandom_range(0, 1)), ovf, q};
  endfunction

  function automatic logic [31:0] random_hit();
    return hit_word(5'($urandom_range(0, 31)), $urandom_range(0, 3) == 0,
                    14'($urandom_range(0, 16'h3FFF)));
  endfunction

  function automatic logic [29:0] random_low30();
    return 30'($urandom());
  endfunction

  function automatic logic [31:0] eoe_word(logic [29:0] hi);
    return {TOP_EOE, hi};
  endfunction

  function automatic logic [31:0] header_word(logic [29:0] rest);
    return {TOP_HEADER, rest};
  endfunction

  function automatic logic [31:0] low_word(logic [15:0] lo);
    return {LOW_STAMP_TAG, lo};
  endfunction

  // drive helpers
  task automatic send_word(input logic [31:0] w, input logic eot);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      word_if.valid <= 1'b0;
    end
    @(negedge clk);
    word_if.valid           <= 1'b1;
    word_if.data_word       <= w;
    word_if.end_of_transfer <= eot;
    forever begin
      @(posedge clk);
      if (word_if.ready) break;
    end
    decode_word(w, eot);
  endtask

  task automatic settle();
    @(negedge clk);
    word_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODULE_ID) begin
      cfg_module = val;
    end else if (idx == CFG_TIMESTAMP_MODE) begin
      cfg_ext_mode = val[0];
      pend_cnt     = 0;
      clear_stamp();
    end
  endtask

  // one event of the extended format with random content
  task automatic send_event();
    int   nh;
    int   lo_at;
    logic eot_end;
    if ($urandom_range(0, 9) < 7) begin
      send_word(header_word(random_low30()), 1'b0);
      words_counted++;
    end
    nh    = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    lo_at = ($urandom_range(0, 4) != 0) ? $urandom_range(0, nh) : -1;
    for (int i = 0; i <= nh; i++) begin
      if (i == lo_at) begin
        send_word(low_word(16'($urandom())), 1'b0);
        words_counted++;
      end
      if ($urandom_range(0, 19) == 0) send_word($urandom(), $urandom_range(0, 9) == 0);
      if (i < nh) begin
        send_word(random_hit(), 1'b0);
        words_counted++;
      end
    end
    eot_end = ($urandom_range(0, 6) == 0);
    if ($urandom_range(0, 9) != 0) begin
      send_word(eoe_word(random_low30()), eot_end);
      words_counted++;
    end else if (eot_end) begin
      send_word(random_hit(), 1'b1);
      words_counted++;
    end
  endtask

  // tests
  task automatic test_counter_directed();
    write_reg(CFG_MODULE_ID, 8'hFF);
    send_word(hit_word(5'd0, 1'b0, 14'h0000), 1'b0);
    send_word(hit_word(5'd31, 1'b0, 14'h3FFF), 1'b0);
    send_word(hit_word(5'd5, 1'b1, 14'h1234), 1'b0);
    send_word(eoe_word(30'h0), 1'b0);
    send_word(hit_word(5'd7, 1'b0, 14'd100), 1'b0);
    send_word(eoe_word(30'h3FFFFFFF), 1'b0);
    send_word(header_word(random_low30()), 1'b0);
    send_word({TOP_IGNORED, 30'h3FFFFFFF}, 1'b0);
    send_word(low_word(16'hBEEF), 1'b0);
    send_word({TOP_PLAIN, 30'h0}, 1'b0);
    send_word({HIT_TAG + 10'd1, 22'h3FFFFF}, 1'b0);
    send_word(hit_word(5'd16, 1'b0, 14'd1), 1'b1);
    send_word(eoe_word(random_low30()), 1'b1);
    send_word(hit_word(5'd9, 1'b1, 14'h3FFF), 1'b0);
    settle();
  endtask

  task automatic test_extended_directed();
    write_reg(CFG_MODULE_ID, 8'h00);
    write_reg(CFG_TIMESTAMP_MODE, 8'd1);
    send_word(header_word(30'h0), 1'b0);
    send_word(hit_word(5'd0, 1'b0, 14'h0000), 1'b0);
    send_word(hit_word(5'd31, 1'b1, 14'h0ABC), 1'b0);
    send_word(hit_word(5'd12, 1'b0, 14'h3FFF), 1'b0);
    send_word(low_word(16'hFFFF), 1'b0);
    send_word(eoe_word(30'h3FFFFFFF), 1'b0);
    // low stamp survives the end of event
    send_word(hit_word(5'd2, 1'b0, 14'd77), 1'b0);
    send_word(eoe_word(30'h0), 1'b0);
    // header drops the low stamp
    send_word(header_word(30'h3FFFFFFF), 1'b0);
    send_word(hit_word(5'd3, 1'b0, 14'd5), 1'b0);
    send_word(eoe_word(30'h12345), 1'b0);
    // header flushes pending hits unstamped
    send_word(hit_word(5'd4, 1'b0, 14'd6), 1'b0);
    send_word(hit_word(5'd5, 1'b1, 14'd7), 1'b0);
    send_word(header_word(random_low30()), 1'b0);
    // end of transfer flushes and clears the low stamp
    send_word(low_word(16'h0000), 1'b0);
    send_word(hit_word(5'd6, 1'b0, 14'd8), 1'b0);
    send_word(low_word(16'h5A5A), 1'b1);
    send_word(hit_word(5'd7, 1'b0, 14'd9), 1'b0);
    send_word(eoe_word(30'h1), 1'b0);
    send_word(eoe_word(30'h2), 1'b0);
    send_word({TOP_IGNORED, 30'h15555555}, 1'b0);
    send_word(low_word(16'h0001), 1'b0);
    send_word(hit_word(5'd8, 1'b0, 14'd10), 1'b0);
    send_word(eoe_word(30'h2AAAAAAA), 1'b1);
    settle();
  endtask

  task automatic test_store_full();
    send_word(header_word(random_low30()), 1'b0);
    repeat (STORE_CAP + 1) send_word(random_hit(), 1'b0);
    send_word(random_hit(), 1'b1);
    repeat (STORE_CAP) send_word(random_hit(), 1'b0);
    send_word(low_word(16'($urandom())), 1'b0);
    send_word(eoe_word(random_low30()), 1'b0);
    settle();
  endtask

  task automatic test_mode_change();
    send_word(low_word(16'h8001), 1'b0);
    repeat (3) send_word(random_hit(), 1'b0);
    settle();
    write_reg(CFG_TIMESTAMP_MODE, 8'd0);
    write_reg(CFG_TIMESTAMP_MODE, 8'd1);
    send_word(eoe_word(random_low30()), 1'b0);
    repeat (2) send_word(random_hit(), 1'b0);
    send_word(eoe_word(random_low30()), 1'b0);
    send_word(low_word(16'h0102), 1'b0);
    send_word(random_hit(), 1'b0);
    settle();
    write_reg(CFG_TIMESTAMP_MODE, 8'd0);
    send_word(random_hit(), 1'b0);
    settle();
  endtask

  task automatic test_random_counter();
    int kind;
    logic [31:0] w;
    write_reg(CFG_MODULE_ID, 8'($urandom()));
    repeat (80) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) w = random_hit();
      else if (kind < 7) w = eoe_word(random_low30());
      else if (kind == 7) w = header_word(random_low30());
      else if (kind == 8) w = $urandom();
      else w = low_word(16'($urandom()));
      send_word(w, $urandom_range(0, 9) == 0);
    end
    settle();
  endtask

  task automatic test_random_extended();
    write_reg(CFG_MODULE_ID, 8'($urandom()));
    write_reg(CFG_TIMESTAMP_MODE, 8'd1);
    words_counted = 0;
    no_idle = 1'b1;
    while (words_counted < 40) send_event();
    no_idle = 1'b0;
    while (words_counted < 80) send_event();
    // hold the sender until every hit is out
    settle();
    write_reg(CFG_MODULE_ID, 8'($urandom()));
    while (words_counted < 130) send_event();
    settle();
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = '0;
    cfg_data                = '0;
    word_if.valid           = 1'b0;
    word_if.data_word       = '0;
    word_if.end_of_transfer = 1'b0;
    hit_if.ready            = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_counter_directed();
    test_extended_directed();
    test_store_full();
    test_mode_change();
    test_random_counter();
    test_random_extended();
    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
